@@ rtl/core/lprp_pkg.sv @@
`timescale 1ns / 1ps

package lprp_pkg;

    // One input word: a raw record byte and its end-of-record mark.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } byte_word_t;

    // One result word.
    typedef struct packed {
        logic [2:0]  field_kind;
        logic [63:0] field_value;
        logic        value_valid;
        logic        record_end;
        logic [2:0]  status;
    } field_word_t;

    // Kinds of emitted field.
    typedef enum logic [2:0] {
        FK_NONE    = 3'd0,
        FK_ISSUER  = 3'd1,
        FK_SUBJECT = 3'd2,
        FK_KEY     = 3'd3,
        FK_START   = 3'd4,
        FK_END     = 3'd5,
        FK_PATH    = 3'd6
    } field_kind_t;

    // Record status codes, also used for the latched error.
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_MAGIC   = 3'd2,
        ST_VERSION = 3'd3,
        ST_TRUNC   = 3'd4,
        ST_TRAIL   = 3'd5
    } status_t;

    // Fixed record constants.
    localparam logic [7:0] MAGIC_0      = 8'h43;  // 'C'
    localparam logic [7:0] MAGIC_1      = 8'h41;  // 'A'
    localparam logic [7:0] MAGIC_2      = 8'h52;  // 'R'
    localparam logic [7:0] MAGIC_3      = 8'h45;  // 'E'
    localparam logic [7:0] VERSION_BYTE = 8'h01;
    localparam logic [2:0] HEADER_BYTES = 3'd5;

    // Last byte positions of the big-endian numbers.
    localparam logic [2:0] LEN_LAST_POS  = 3'd3;
    localparam logic [2:0] TIME_LAST_POS = 3'd7;

endpackage

@@ rtl/core/lprp_parse.sv @@
`timescale 1ns / 1ps

module lprp_parse
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step_en,
    input  lprp_pkg::byte_word_t      byte_in,
    output lprp_pkg::field_word_t     result
);
    import lprp_pkg::*;

    // Parser phase, one-hot.
    typedef enum logic [14:0] {
        PH_MAGIC0      = 15'b000000000000001,
        PH_MAGIC1      = 15'b000000000000010,
        PH_MAGIC2      = 15'b000000000000100,
        PH_MAGIC3      = 15'b000000000001000,
        PH_VERSION     = 15'b000000000010000,
        PH_ISSUER_LEN  = 15'b000000000100000,
        PH_ISSUER_BODY = 15'b000000001000000,
        PH_SUBJ_LEN    = 15'b000000010000000,
        PH_SUBJ_BODY   = 15'b000000100000000,
        PH_KEY_LEN     = 15'b000001000000000,
        PH_KEY_BODY    = 15'b000010000000000,
        PH_TIME_START  = 15'b000100000000000,
        PH_TIME_END    = 15'b001000000000000,
        PH_PATH        = 15'b010000000000000,
        PH_DONE        = 15'b100000000000000
    } phase_t;

    phase_t      phase_reg,  phase_next;
    logic [2:0]  hdr_reg,    hdr_next;
    logic [63:0] accum_reg,  accum_next;
    logic [2:0]  pos_reg,    pos_next;
    logic [31:0] remain_reg, remain_next;
    status_t     err_reg,    err_next;

    logic [63:0] gathered;
    logic        len_done;
    logic        len_zero;
    logic        time_done;
    logic        body_done;
    field_kind_t kind;
    logic [63:0] value;
    logic        value_vld;
    status_t     status;

    // Accumulator with the new byte shifted in, and completion flags.
    always_comb
    begin
        gathered  = {accum_reg[55:0], byte_in.data_byte};
        len_done  = (pos_reg == LEN_LAST_POS);
        len_zero  = (gathered[31:0] == 32'd0);
        time_done = (pos_reg == TIME_LAST_POS);
        body_done = (remain_reg == 32'd1);
    end

    // Next state and result for the byte in the input register.
    always_comb
    begin
        phase_next  = phase_reg;
        hdr_next    = (hdr_reg < HEADER_BYTES) ? hdr_reg + 3'd1 : hdr_reg;
        accum_next  = accum_reg;
        pos_next    = pos_reg;
        remain_next = remain_reg;
        err_next    = err_reg;
        kind        = FK_NONE;
        value       = '0;
        value_vld   = 1'b0;
        status      = ST_OK;

        if (err_reg == ST_OK)
        begin
            unique case (phase_reg)
                PH_MAGIC0:
                begin
                    if (byte_in.data_byte != MAGIC_0)
                    begin
                        err_next = ST_MAGIC;
                    end
                    phase_next = PH_MAGIC1;
                end
                PH_MAGIC1:
                begin
                    if (byte_in.data_byte != MAGIC_1)
                    begin
                        err_next = ST_MAGIC;
                    end
                    phase_next = PH_MAGIC2;
                end
                PH_MAGIC2:
                begin
                    if (byte_in.data_byte != MAGIC_2)
                    begin
                        err_next = ST_MAGIC;
                    end
                    phase_next = PH_MAGIC3;
                end
                PH_MAGIC3:
                begin
                    if (byte_in.data_byte != MAGIC_3)
                    begin
                        err_next = ST_MAGIC;
                    end
                    phase_next = PH_VERSION;
                end
                PH_VERSION:
                begin
                    if (byte_in.data_byte != VERSION_BYTE)
                    begin
                        err_next = ST_VERSION;
                    end
                    phase_next = PH_ISSUER_LEN;
                end
                PH_ISSUER_LEN, PH_SUBJ_LEN, PH_KEY_LEN:
                begin
                    accum_next = gathered;
                    pos_next   = pos_reg + 3'd1;
                    if (len_done)
                    begin
                        remain_next = gathered[31:0];
                        accum_next  = '0;
                        pos_next    = '0;
                        // A zero-length body is skipped altogether.
                        if (phase_reg == PH_ISSUER_LEN)
                        begin
                            phase_next = len_zero ? PH_SUBJ_LEN : PH_ISSUER_BODY;
                        end
                        else if (phase_reg == PH_SUBJ_LEN)
                        begin
                            phase_next = len_zero ? PH_KEY_LEN : PH_SUBJ_BODY;
                        end
                        else
                        begin
                            phase_next = len_zero ? PH_TIME_START : PH_KEY_BODY;
                        end
                    end
                end
                PH_ISSUER_BODY, PH_SUBJ_BODY, PH_KEY_BODY:
                begin
                    value       = {56'd0, byte_in.data_byte};
                    value_vld   = 1'b1;
                    remain_next = remain_reg - 32'd1;
                    if (phase_reg == PH_ISSUER_BODY)
                    begin
                        kind = FK_ISSUER;
                        if (body_done)
                        begin
                            phase_next = PH_SUBJ_LEN;
                        end
                    end
                    else if (phase_reg == PH_SUBJ_BODY)
                    begin
                        kind = FK_SUBJECT;
                        if (body_done)
                        begin
                            phase_next = PH_KEY_LEN;
                        end
                    end
                    else
                    begin
                        kind = FK_KEY;
                        if (body_done)
                        begin
                            phase_next = PH_TIME_START;
                        end
                    end
                end
                PH_TIME_START, PH_TIME_END:
                begin
                    accum_next = gathered;
                    pos_next   = pos_reg + 3'd1;
                    if (time_done)
                    begin
                        kind       = (phase_reg == PH_TIME_START) ? FK_START : FK_END;
                        value      = gathered;
                        value_vld  = 1'b1;
                        accum_next = '0;
                        pos_next   = '0;
                        phase_next = (phase_reg == PH_TIME_START) ? PH_TIME_END : PH_PATH;
                    end
                end
                PH_PATH:
                begin
                    accum_next = gathered;
                    pos_next   = pos_reg + 3'd1;
                    if (len_done)
                    begin
                        kind       = FK_PATH;
                        value      = {32'd0, gathered[31:0]};
                        value_vld  = 1'b1;
                        accum_next = '0;
                        pos_next   = '0;
                        phase_next = PH_DONE;
                    end
                end
                PH_DONE:
                begin
                    err_next = ST_TRAIL;
                end
                default:
                begin
                    phase_next = PH_MAGIC0;
                end
            endcase
        end

        // End of record: report the status and return to the reset state.
        if (byte_in.is_last)
        begin
            priority if (hdr_next < HEADER_BYTES)
            begin
                status = ST_SHORT;
            end
            else if (err_next != ST_OK)
            begin
                status = err_next;
            end
            else if (phase_next != PH_DONE)
            begin
                status = ST_TRUNC;
            end
            else
            begin
                status = ST_OK;
            end
            phase_next  = PH_MAGIC0;
            hdr_next    = '0;
            accum_next  = '0;
            pos_next    = '0;
            remain_next = '0;
            err_next    = ST_OK;
        end
    end

    // Parser state, advanced once per byte handed to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MAGIC0;
            hdr_reg    <= '0;
            accum_reg  <= '0;
            pos_reg    <= '0;
            remain_reg <= '0;
            err_reg    <= ST_OK;
        end
        else if (step_en)
        begin
            phase_reg  <= phase_next;
            hdr_reg    <= hdr_next;
            accum_reg  <= accum_next;
            pos_reg    <= pos_next;
            remain_reg <= remain_next;
            err_reg    <= err_next;
        end
    end

    // Result word for the current byte.
    always_comb
    begin
        result.field_kind  = kind;
        result.field_value = value;
        result.value_valid = value_vld;
        result.record_end  = byte_in.is_last;
        result.status      = status;
    end

endmodule

@@ rtl/core/length_prefixed_record_parser.sv @@
`timescale 1ns / 1ps

// Streaming parser for length-prefixed records ("CARE" magic, version 1, issuer,
// subject and key bodies with 32-bit big-endian lengths, two 64-bit times and a
// 32-bit path length). Record bytes enter one word per cycle on the byte channel;
// each byte gives exactly one result word on the field channel, passing through
// the input register and then the result register.
// The sustained rate is one byte per clock, set by the single parser update done
// between those two registers; while a result waits in the output register the
// byte channel takes at most one more byte, held in the input register, and then
// stalls until the result is taken. Body bytes appear as they arrive, numbers when
// their last byte arrives, and the status is valid on the word with record_end
// set; after the first error a record emits no further fields, and fields already
// emitted for a failed record are to be discarded by the consumer.
module length_prefixed_record_parser
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_ready,
    input  lprp_pkg::byte_word_t  byte_word,
    output logic                  field_valid,
    input  logic                  field_ready,
    output lprp_pkg::field_word_t field_word
);
    import lprp_pkg::*;

    logic        in_vld_reg,   in_vld_next;
    byte_word_t  in_word_reg;
    logic        out_vld_reg,  out_vld_next;
    field_word_t out_word_reg;
    logic        advance;
    logic        byte_take;
    field_word_t step_result;

    // Pipeline handshake: the held byte moves on when the result slot is free.
    always_comb
    begin
        advance      = in_vld_reg && (!out_vld_reg || field_ready);
        byte_ready   = !in_vld_reg || advance;
        byte_take    = byte_valid && byte_ready;
        in_vld_next  = byte_take || (in_vld_reg && !advance);
        out_vld_next = advance || (out_vld_reg && !field_ready);
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (byte_take)
        begin
            in_word_reg <= byte_word;
        end
        if (advance)
        begin
            out_word_reg <= step_result;
        end
    end

    // Parser state and per-byte logic.
    lprp_parse u_parse
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .byte_in (in_word_reg),
        .result  (step_result)
    );

    assign field_valid = out_vld_reg;
    assign field_word  = out_word_reg;

endmodule
